/* rtl/core/sbmq_pkg.sv */
// ----------------------------------------------------------------------------
// sbmq_pkg
// Types and constants shared by the shared-buffer multi-queue design.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int DATA_W = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic                     opcode;
        logic [2:0]               queue_sel;
        logic signed [DATA_W-1:0] data_in;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data_out;
    } out_t;

endpackage

/* rtl/core/sbmq_ram.sv */
// ----------------------------------------------------------------------------
// sbmq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds while no new read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/sbmq_qtab.sv */
// ----------------------------------------------------------------------------
// sbmq_qtab
// Queue table: head and tail pointer of every queue in one synchronous memory.
// ----------------------------------------------------------------------------
module sbmq_qtab #(
    parameter int QUEUES  = 8,
    parameter int ENTRIES = 1024,
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1,
    localparam int PW = $clog2(ENTRIES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [QW-1:0] rd_addr,
    output logic [PW-1:0] rd_head,
    output logic [PW-1:0] rd_tail,
    input  logic          wr_en,
    input  logic [QW-1:0] wr_addr,
    input  logic [PW-1:0] wr_head,
    input  logic [PW-1:0] wr_tail
);

    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    logic [2*PW-1:0]   mem [QUEUES];
    logic [QUEUES-1:0] valid_reg;
    logic [2*PW-1:0]   rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_head, wr_tail};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A queue entry that was never written reads as empty (both pointers null).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_head = rd_valid_reg ? rd_data_reg[2*PW-1:PW] : NULL_PTR;
    assign rd_tail = rd_valid_reg ? rd_data_reg[PW-1:0] : NULL_PTR;

endmodule

/* rtl/core/shared_buffer_multi_queue_top.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// Several FIFO queues sharing one entry store, with a linked free list.
// ----------------------------------------------------------------------------
// m_valid rises after the queue-table read for an enqueue or an underflowing dequeue,
// and after the queue-table read and then the link and data memory reads for a
// dequeue that pops; each of these memory reads is registered.
// The block takes one item at a time; the next is accepted while a result waits,
// but it cannot finish until m_ready.
// Reset needs no clearing pass: entries at or above the fill pointer read their reset link.
module shared_buffer_multi_queue_top #(
    parameter int QUEUES  = 8,
    parameter int ENTRIES = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sbmq_pkg::in_t s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output sbmq_pkg::out_t m_payload
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_POP  = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    sbmq_pkg::in_t  item_reg, item_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [PW-1:0]  free_head_reg, free_head_next;
    logic [PW-1:0]  fill_reg, fill_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic           link_hit_reg, link_hit_next;
    logic [PW-1:0]  link_base_reg, link_base_next;
    logic           m_valid_reg, m_valid_next;
    sbmq_pkg::out_t out_reg, out_next;

    logic [PW-1:0]  qt_head, qt_tail;
    logic           qt_rd_en, qt_wr_en;
    logic [PW-1:0]  qt_wr_head, qt_wr_tail;

    logic                      link_rd_en, link_wr_en;
    logic [AW-1:0]             link_rd_addr, link_wr_addr;
    logic [PW-1:0]             link_wr_data, link_rd;
    logic                      data_rd_en, data_wr_en;
    logic [sbmq_pkg::DATA_W-1:0] data_rd;

    logic           accept, can_out, finish;
    logic [PW-1:0]  link_val, pop_head;
    sbmq_pkg::out_t result;

    // Folds a queue select onto the configured queue count by compare and subtract.
    function automatic logic [QW-1:0] queue_index(input logic [2:0] sel);
        int idx;
        idx = int'(sel);
        for (int i = 0; i < 8; i++) begin
            if (idx >= QUEUES) begin
                idx = idx - QUEUES;
            end
        end
        return QW'(idx);
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign can_out   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // A link that was never written still holds its reset value, the next entry.
    assign link_val = link_hit_reg ? PW'(link_base_reg + PW'(1)) : link_rd;
    // The tail entry is the last one, so popping it leaves the queue empty.
    assign pop_head = (head_reg == tail_reg) ? NULL_PTR : link_val;

    sbmq_qtab #(
        .QUEUES  (QUEUES),
        .ENTRIES (ENTRIES)
    ) u_qtab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (qt_rd_en),
        .rd_addr (q_next),
        .rd_head (qt_head),
        .rd_tail (qt_tail),
        .wr_en   (qt_wr_en),
        .wr_addr (q_reg),
        .wr_head (qt_wr_head),
        .wr_tail (qt_wr_tail)
    );

    sbmq_ram #(
        .WIDTH (PW),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd)
    );

    sbmq_ram #(
        .WIDTH (sbmq_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (data_wr_en),
        .wr_addr (free_head_reg[AW-1:0]),
        .wr_data (item_reg.data_in),
        .rd_en   (data_rd_en),
        .rd_addr (qt_head[AW-1:0]),
        .rd_data (data_rd)
    );

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        q_next         = q_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        link_hit_next  = link_hit_reg;
        link_base_next = link_base_reg;
        qt_rd_en       = 1'b0;
        qt_wr_en       = 1'b0;
        qt_wr_head     = qt_head;
        qt_wr_tail     = qt_tail;
        link_rd_en     = 1'b0;
        link_rd_addr   = free_head_reg[AW-1:0];
        link_wr_en     = 1'b0;
        link_wr_addr   = qt_tail[AW-1:0];
        link_wr_data   = free_head_reg;
        data_rd_en     = 1'b0;
        data_wr_en     = 1'b0;
        finish         = 1'b0;
        result.status   = sbmq_pkg::STAT_OK;
        result.data_out = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_next      = s_payload;
                    q_next         = queue_index(s_payload.queue_sel);
                    qt_rd_en       = 1'b1;
                    // Fetch the link of the free-list head for a possible enqueue.
                    link_rd_en     = 1'b1;
                    link_rd_addr   = free_head_reg[AW-1:0];
                    link_hit_next  = (free_head_reg >= fill_reg);
                    link_base_next = free_head_reg;
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                if (item_reg.opcode == sbmq_pkg::OP_ENQ) begin
                    if (can_out) begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                        if (free_head_reg >= NULL_PTR) begin
                            result.status = sbmq_pkg::STAT_OVERFLOW;
                        end else begin
                            data_wr_en     = 1'b1;
                            qt_wr_en       = 1'b1;
                            qt_wr_tail     = free_head_reg;
                            free_head_next = link_val;
                            if (free_head_reg >= fill_reg) begin
                                fill_next = PW'(free_head_reg + PW'(1));
                            end
                            if (qt_head < NULL_PTR) begin
                                link_wr_en   = 1'b1;
                                link_wr_addr = qt_tail[AW-1:0];
                                link_wr_data = free_head_reg;
                            end else begin
                                qt_wr_head = free_head_reg;
                            end
                        end
                    end
                end else begin
                    if (qt_head < NULL_PTR) begin
                        link_rd_en     = 1'b1;
                        link_rd_addr   = qt_head[AW-1:0];
                        data_rd_en     = 1'b1;
                        link_hit_next  = (qt_head >= fill_reg);
                        link_base_next = qt_head;
                        head_next      = qt_head;
                        tail_next      = qt_tail;
                        state_next     = S_POP;
                    end else if (can_out) begin
                        finish        = 1'b1;
                        result.status = sbmq_pkg::STAT_UNDERFLOW;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_POP: begin
                if (can_out) begin
                    finish          = 1'b1;
                    result.data_out = data_rd;
                    link_wr_en      = 1'b1;
                    link_wr_addr    = head_reg[AW-1:0];
                    link_wr_data    = free_head_reg;
                    free_head_next  = head_reg;
                    qt_wr_en        = 1'b1;
                    qt_wr_head      = pop_head;
                    qt_wr_tail      = tail_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (finish) begin
            m_valid_next = 1'b1;
            out_next     = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        q_reg         <= q_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        link_hit_reg  <= link_hit_next;
        link_base_reg <= link_base_next;
        out_reg       <= out_next;
    end

    // A new result only appears as the end of an operation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg != S_IDLE))
        else $error("result raised without an operation in progress");

    // The free-list head and fill pointer never leave the pointer range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NULL_PTR && fill_reg <= NULL_PTR)
        else $error("free-list pointer out of range");

    // The fill pointer only grows between resets.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |=> fill_reg >= $past(fill_reg))
        else $error("fill pointer moved backward");

    // An enqueue never reports underflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && item_reg.opcode == sbmq_pkg::OP_ENQ)
            |=> out_reg.status != sbmq_pkg::STAT_UNDERFLOW)
        else $error("enqueue transaction reported underflow");

endmodule

/* tb/sv/sbmq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_checker
// Watches both channels of the shared-buffer multi-queue. It keeps its own
// copy of the queue heads, tails, link memory and free list, predicts the
// result of every accepted operation and compares each returned result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module sbmq_checker #(
    parameter int QUEUES  = 8,
    parameter int ENTRIES = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  sbmq_pkg::in_t  s_payload,
    input  logic           m_valid,
    input  logic           m_ready,
    input  sbmq_pkg::out_t m_payload,
    output int             fail_count,
    output int             pending
);

    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam logic [PTR_W-1:0] NIL = ENTRIES[PTR_W-1:0];

    logic [PTR_W-1:0]            head_ptr [QUEUES];
    logic [PTR_W-1:0]            tail_ptr [QUEUES];
    logic [PTR_W-1:0]            next_ptr [ENTRIES];
    logic [sbmq_pkg::DATA_W-1:0] word_mem [ENTRIES];
    logic [PTR_W-1:0]            free_ptr;

    sbmq_pkg::out_t op_results_q [$];
    int             mismatches = 0;

    function automatic void clear_queues();
        for (int i = 0; i < QUEUES; i++) begin
            head_ptr[i] = NIL;
            tail_ptr[i] = NIL;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            next_ptr[i] = (i + 1 < ENTRIES) ? PTR_W'(i + 1) : NIL;
            word_mem[i] = '0;
        end
        free_ptr = '0;
    endfunction

    // Applies one operation to the shadow lists and returns its result.
    function automatic sbmq_pkg::out_t run_queue_op(input sbmq_pkg::in_t op_item);
        sbmq_pkg::out_t   res;
        int               q;
        logic [PTR_W-1:0] slot;
        q = int'(op_item.queue_sel) % QUEUES;
        res.status   = sbmq_pkg::STAT_OK;
        res.data_out = '0;
        if (op_item.opcode == sbmq_pkg::OP_ENQ) begin
            slot = free_ptr;
            if (slot >= ENTRIES) begin
                res.status = sbmq_pkg::STAT_OVERFLOW;
            end else begin
                free_ptr = next_ptr[slot];
                if (head_ptr[q] >= ENTRIES) begin
                    head_ptr[q] = slot;
                end else if (tail_ptr[q] < ENTRIES) begin
                    next_ptr[tail_ptr[q]] = slot;
                end
                next_ptr[slot] = NIL;
                tail_ptr[q]    = slot;
                word_mem[slot] = op_item.data_in;
            end
        end else begin
            slot = head_ptr[q];
            if (slot >= ENTRIES) begin
                res.status = sbmq_pkg::STAT_UNDERFLOW;
            end else begin
                // The tail of an emptied queue is left stale on purpose.
                head_ptr[q]    = next_ptr[slot];
                next_ptr[slot] = free_ptr;
                free_ptr       = slot;
                res.data_out   = word_mem[slot];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        sbmq_pkg::out_t want;
        if (!aresetn) begin
            clear_queues();
            op_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (op_results_q.size() == 0) begin
                    $error("result transaction with no operation outstanding");
                    mismatches++;
                end else begin
                    want = op_results_q.pop_front();
                    if (m_payload.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_payload.status);
                        mismatches++;
                    end
                    if (m_payload.data_out !== want.data_out) begin
                        $error("data_out: expected %0d, actual %0d",
                               want.data_out, m_payload.data_out);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                op_results_q.push_back(run_queue_op(s_payload));
            end
        end
        fail_count <= mismatches;
        pending    <= op_results_q.size();
    end

endmodule

/* tb/sv/shared_buffer_multi_queue_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top_tb
// Drives enqueue and dequeue operations into the shared-buffer multi-queue:
// a directed set of edge cases, then random traffic that fills the shared
// store to overflow and then sends mostly dequeues, under varying back-pressure.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top_tb;

    localparam int QUEUES      = 8;
    localparam int ENTRIES     = 1024;
    localparam int CYCLE_LIMIT = 400000;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    sbmq_pkg::in_t  s_payload = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    sbmq_pkg::out_t m_payload;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Occupancy as seen from the stimulus side, used only to shape traffic.
    int queue_len [QUEUES];
    int occupancy = 0;

    shared_buffer_multi_queue_top #(
        .QUEUES (QUEUES),
        .ENTRIES(ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    sbmq_checker #(
        .QUEUES (QUEUES),
        .ENTRIES(ENTRIES)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic sbmq_pkg::in_t make_op(input logic op, input int q,
                                              input logic [31:0] word);
        sbmq_pkg::in_t item;
        item.opcode    = op;
        item.queue_sel = q[2:0];
        item.data_in   = word;
        return item;
    endfunction

    task automatic send_item(input sbmq_pkg::in_t item);
        int q;
        q = int'(item.queue_sel) % QUEUES;
        if (item.opcode == sbmq_pkg::OP_ENQ) begin
            if (occupancy < ENTRIES) begin
                queue_len[q]++;
                occupancy++;
            end
        end else if (queue_len[q] > 0) begin
            queue_len[q]--;
            occupancy--;
        end
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(input int enq_pct);
        int          q;
        int          pick;
        logic [31:0] word;
        q = $urandom_range(QUEUES - 1);
        if ($urandom_range(99) < enq_pct) begin
            word = $urandom;
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'h0000_0000;
                    default: word = 32'hFFFF_FFFF;
                endcase
            end
            send_item(make_op(sbmq_pkg::OP_ENQ, q, word));
        end else begin
            // Most dequeues go to a queue that holds something.
            pick = -1;
            if (queue_len[q] == 0 && $urandom_range(3) != 0) begin
                for (int k = 0; k < QUEUES; k++) begin
                    if (pick < 0 && queue_len[(q + k) % QUEUES] != 0) begin
                        pick = (q + k) % QUEUES;
                    end
                end
            end
            if (pick >= 0) begin
                q = pick;
            end
            send_item(make_op(sbmq_pkg::OP_DEQ, q, $urandom));
        end
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < QUEUES; i++) begin
            queue_len[i] = 0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 54;

        // Underflow on queues that have never held anything.
        send_item(make_op(sbmq_pkg::OP_DEQ, 0, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 7, 32'hFFFF_FFFF));
        send_item(make_op(sbmq_pkg::OP_ENQ, 0, 32'h8000_0000));
        send_item(make_op(sbmq_pkg::OP_ENQ, 0, 32'h7FFF_FFFF));
        send_item(make_op(sbmq_pkg::OP_ENQ, 7, 32'h0000_0000));
        send_item(make_op(sbmq_pkg::OP_ENQ, 7, 32'hFFFF_FFFF));
        send_item(make_op(sbmq_pkg::OP_ENQ, 3, 32'hAAAA_AAAA));
        send_item(make_op(sbmq_pkg::OP_ENQ, 4, 32'h5555_5555));
        send_item(make_op(sbmq_pkg::OP_DEQ, 0, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 0, 32'h0));
        // The queue is now empty with a stale tail; refill it and drain again.
        send_item(make_op(sbmq_pkg::OP_DEQ, 0, 32'h0));
        send_item(make_op(sbmq_pkg::OP_ENQ, 0, 32'h1234_5678));
        send_item(make_op(sbmq_pkg::OP_DEQ, 7, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 7, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 7, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 3, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 4, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 0, 32'h0));
        for (int q = 1; q < 7; q++) begin
            send_item(make_op(sbmq_pkg::OP_ENQ, q, 32'hC000_0000 | q));
        end
        send_item(make_op(sbmq_pkg::OP_DEQ, 2, 32'h0));
        send_item(make_op(sbmq_pkg::OP_DEQ, 5, 32'h0));

        repeat (250) send_random(75);
        wait_results();

        // Fill the whole store, then keep pushing against overflow.
        send_idle_pct = 54;
        recv_idle_pct = 21;
        while (occupancy < ENTRIES) send_random(95);
        repeat (60) send_random(75);
        wait_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (250) send_random(20);

        wait_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
